/* hw/rtl/ffha_pkg.sv */
// shared types, constants and helpers for the first-fit heap allocator
`default_nettype none

package ffha_pkg;

  localparam int ARENA_BYTES_DEF = 4096;
  localparam int HDR_W  = 16;
  localparam int FLD_W  = 12;
  localparam int STAT_W = 3;
  localparam int EW     = 18;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK       = 3'd0,
    STAT_NOSPACE  = 3'd1,
    STAT_RANGE    = 3'd2,
    STAT_NOTFOUND = 3'd3,
    STAT_DOUBLE   = 3'd4
  } stat_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_READ,
    S_AEVAL,
    S_ASPLIT,
    S_FEVAL,
    S_FMERGE,
    S_RESULT
  } state_e;

  typedef enum logic [1:0] {
    WR_INIT,
    WR_ALLOC,
    WR_SPLIT,
    WR_MERGE
  } wr_sel_e;

  typedef enum logic {
    RD_POS,
    RD_NXT
  } rd_sel_e;

  typedef struct packed {
    logic    load_req;
    logic    set_ready;
    logic    walk_start;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    wr_en;
    wr_sel_e wr_sel;
    logic    latch_h;
    logic    latch_right;
    logic    advance;
    logic    set_res;
    stat_e   res_code;
    logic    res_pay;
    logic    out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic op_free;
    logic arena_ready;
    logic size_bad;
    logic target_bad;
    logic blk_bad;
    logic fit;
    logic spare_nz;
    logic at_target;
    logic past_target;
    logic h_neg;
    logic end_reached;
  } dp_sts_t;

  function automatic logic [EW-1:0] hdr_mag(input logic [HDR_W-1:0] h);
    logic [EW-1:0] ext;
    ext = {{(EW-HDR_W){h[HDR_W-1]}}, h};
    return h[HDR_W-1] ? (~ext + EW'(1)) : ext;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/first_fit_heap_allocator_core.sv */
// top level of the first-fit heap allocator with coalescing
// Each transfer on the slave side is one allocate or free request and gives exactly one
// result transfer. The arena is an implicit list of signed 2-byte headers kept in a
// single header memory with one registered read port and one write port; requests are
// handled one at a time. A request rejected up front goes from the check state straight
// to the result state; otherwise the walk visits blocks in turn, each with a header read
// (READ) and an evaluate step (AEVAL or FEVAL), then a split or merge write may follow. The
// header memory needs no clearing pass; the arena is set up by the first allocate.
// The next request is taken while a finished result still waits on the master side.
`default_nettype none

module first_fit_heap_allocator_core
  import ffha_pkg::*;
#(
  parameter int ARENA_BYTES = ARENA_BYTES_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,   // request_size, free_offset
  input  wire logic        s_axis_tuser,   // opcode
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata    // status, payload_offset, zero pad
);

  dp_cmd_t           cmd;
  dp_sts_t           sts;
  logic [STAT_W-1:0] status;
  logic [FLD_W-1:0]  payload;

  ffha_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ffha_dp #(
    .ARENA_BYTES (ARENA_BYTES)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .op_i      (s_axis_tuser),
    .size_i    (s_axis_tdata[11:0]),
    .target_i  (s_axis_tdata[23:12]),
    .status_o  (status),
    .payload_o (payload)
  );

  assign m_axis_tdata = {1'b0, payload, status};

endmodule

`default_nettype wire

/* hw/rtl/ffha_dp.sv */
// datapath: header memory, walk registers, block arithmetic and result registers
`default_nettype none

module ffha_dp
  import ffha_pkg::*;
#(
  parameter int ARENA_BYTES = ARENA_BYTES_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire dp_cmd_t           cmd_i,
  output dp_sts_t                sts_o,
  input  wire logic              op_i,
  input  wire logic [FLD_W-1:0]  size_i,
  input  wire logic [FLD_W-1:0]  target_i,
  output logic [STAT_W-1:0]      status_o,
  output logic [FLD_W-1:0]       payload_o
);

  localparam int AW = $clog2(ARENA_BYTES);
  localparam int PW = $clog2(ARENA_BYTES + 1);
  localparam logic [EW-1:0] ARENA_W = EW'(ARENA_BYTES);
  localparam logic [EW-1:0] SIZE_MAX = EW'(ARENA_BYTES - 2);
  localparam logic [EW-1:0] TGT_MAX  = EW'(ARENA_BYTES - 3);

  logic [HDR_W-1:0] mem [ARENA_BYTES];
  logic [HDR_W-1:0] rdata_q;

  logic             arena_ready_q;
  logic             op_q;
  logic [FLD_W-1:0] size_q, target_q;
  logic [PW-1:0]    pos_q;
  logic [AW-1:0]    before_q;
  logic [HDR_W-1:0] hb_q, cur_h_q;
  logic             have_left_q, right_ok_q;
  logic [STAT_W-1:0] res_status_q, out_status_q;
  logic [FLD_W-1:0]  res_payload_q, out_payload_q;

  logic [EW-1:0] pos_w, mag, end_sum, need, spare, cur_spare, tgt_w;
  logic          right_ok_c, left_c, right_c;
  logic [AW-1:0] raddr, waddr;
  logic [HDR_W-1:0] wdata;
  logic [HDR_W:0] hb_x, h_x, hn_x, merge_sum;

  assign pos_w     = EW'(pos_q);
  assign mag       = hdr_mag(rdata_q);
  assign end_sum   = pos_w + mag;
  assign need      = EW'(size_q) + EW'(2);
  assign spare     = mag - need;
  assign cur_spare = hdr_mag(cur_h_q) - need;
  assign tgt_w     = EW'(target_q);
  assign right_ok_c = end_sum < ARENA_W;

  always_comb begin
    sts_o.op_free     = op_q;
    sts_o.arena_ready = arena_ready_q;
    sts_o.size_bad    = (size_q == '0) || (EW'(size_q) > SIZE_MAX);
    sts_o.target_bad  = tgt_w > TGT_MAX;
    sts_o.blk_bad     = (mag < EW'(2)) || (end_sum > ARENA_W);
    sts_o.h_neg       = rdata_q[HDR_W-1];
    sts_o.fit         = rdata_q[HDR_W-1] && (mag >= need) &&
                        ((spare == '0) || (spare > EW'(2)));
    sts_o.spare_nz    = spare != '0;
    sts_o.at_target   = (pos_w + EW'(2)) == tgt_w;
    sts_o.past_target = (pos_w + EW'(2)) > tgt_w;
    sts_o.end_reached = end_sum >= ARENA_W;
  end

  assign left_c  = have_left_q && hb_q[HDR_W-1];
  assign right_c = right_ok_q && rdata_q[HDR_W-1];
  assign hb_x = {hb_q[HDR_W-1], hb_q};
  assign h_x  = {cur_h_q[HDR_W-1], cur_h_q};
  assign hn_x = {rdata_q[HDR_W-1], rdata_q};

  always_comb begin
    priority if (left_c && right_c) begin
      merge_sum = hb_x - h_x + hn_x;
    end else if (left_c) begin
      merge_sum = hb_x - h_x;
    end else if (right_c) begin
      merge_sum = hn_x - h_x;
    end else begin
      merge_sum = '0 - h_x;
    end
  end

  always_comb begin
    unique case (cmd_i.rd_sel)
      RD_POS:  raddr = AW'(pos_q);
      RD_NXT:  raddr = right_ok_c ? AW'(end_sum) : '0;
      default: raddr = '0;
    endcase
  end

  always_comb begin
    unique case (cmd_i.wr_sel)
      WR_INIT: begin
        waddr = '0;
        wdata = HDR_W'(~ARENA_W + EW'(1));
      end
      WR_ALLOC: begin
        waddr = AW'(pos_q);
        wdata = HDR_W'(need);
      end
      WR_SPLIT: begin
        waddr = AW'(pos_w + need);
        wdata = HDR_W'(~cur_spare + EW'(1));
      end
      WR_MERGE: begin
        waddr = left_c ? before_q : AW'(pos_q);
        wdata = merge_sum[HDR_W-1:0];
      end
      default: begin
        waddr = '0;
        wdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem[waddr] <= wdata;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arena_ready_q <= 1'b0;
    end else if (cmd_i.set_ready) begin
      arena_ready_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      op_q     <= op_i;
      size_q   <= size_i;
      target_q <= target_i;
    end
    if (cmd_i.walk_start) begin
      pos_q       <= '0;
      have_left_q <= 1'b0;
    end
    if (cmd_i.latch_h) begin
      cur_h_q <= rdata_q;
    end
    if (cmd_i.latch_right) begin
      right_ok_q <= right_ok_c;
    end
    if (cmd_i.advance) begin
      before_q    <= AW'(pos_q);
      hb_q        <= rdata_q;
      have_left_q <= 1'b1;
      pos_q       <= PW'(end_sum);
    end
    if (cmd_i.set_res) begin
      res_status_q  <= cmd_i.res_code;
      res_payload_q <= cmd_i.res_pay ? FLD_W'(pos_w + EW'(2)) : '0;
    end
    if (cmd_i.out_load) begin
      out_status_q  <= res_status_q;
      out_payload_q <= res_payload_q;
    end
  end

  assign status_o  = out_status_q;
  assign payload_o = out_payload_q;

endmodule

`default_nettype wire

/* hw/rtl/ffha_ctrl.sv */
// controller: request sequencing state machine and output handshake
`default_nettype none

module ffha_ctrl
  import ffha_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  input  wire dp_sts_t sts_i,
  output dp_cmd_t      cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_req = 1'b1;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!sts_i.op_free) begin
          if (!sts_i.arena_ready) begin
            cmd_o.wr_en     = 1'b1;
            cmd_o.wr_sel    = WR_INIT;
            cmd_o.set_ready = 1'b1;
          end
          if (sts_i.size_bad) begin
            cmd_o.set_res  = 1'b1;
            cmd_o.res_code = STAT_NOSPACE;
            state_d = S_RESULT;
          end else begin
            cmd_o.walk_start = 1'b1;
            state_d = S_READ;
          end
        end else begin
          priority if (sts_i.target_bad) begin
            cmd_o.set_res  = 1'b1;
            cmd_o.res_code = STAT_RANGE;
            state_d = S_RESULT;
          end else if (!sts_i.arena_ready) begin
            cmd_o.set_res  = 1'b1;
            cmd_o.res_code = STAT_NOTFOUND;
            state_d = S_RESULT;
          end else begin
            cmd_o.walk_start = 1'b1;
            state_d = S_READ;
          end
        end
      end
      S_READ: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RD_POS;
        state_d = sts_i.op_free ? S_FEVAL : S_AEVAL;
      end
      S_AEVAL: begin
        cmd_o.latch_h = 1'b1;
        priority if (sts_i.blk_bad) begin
          cmd_o.set_res  = 1'b1;
          cmd_o.res_code = STAT_NOSPACE;
          state_d = S_RESULT;
        end else if (sts_i.fit) begin
          cmd_o.wr_en  = 1'b1;
          cmd_o.wr_sel = WR_ALLOC;
          if (sts_i.spare_nz) begin
            state_d = S_ASPLIT;
          end else begin
            cmd_o.set_res  = 1'b1;
            cmd_o.res_code = STAT_OK;
            cmd_o.res_pay  = 1'b1;
            state_d = S_RESULT;
          end
        end else begin
          cmd_o.advance = 1'b1;
          if (sts_i.end_reached) begin
            cmd_o.set_res  = 1'b1;
            cmd_o.res_code = STAT_NOSPACE;
            state_d = S_RESULT;
          end else begin
            state_d = S_READ;
          end
        end
      end
      S_ASPLIT: begin
        cmd_o.wr_en    = 1'b1;
        cmd_o.wr_sel   = WR_SPLIT;
        cmd_o.set_res  = 1'b1;
        cmd_o.res_code = STAT_OK;
        cmd_o.res_pay  = 1'b1;
        state_d = S_RESULT;
      end
      S_FEVAL: begin
        cmd_o.latch_h = 1'b1;
        priority if (sts_i.blk_bad || sts_i.past_target) begin
          cmd_o.set_res  = 1'b1;
          cmd_o.res_code = STAT_NOTFOUND;
          state_d = S_RESULT;
        end else if (sts_i.at_target) begin
          if (sts_i.h_neg) begin
            cmd_o.set_res  = 1'b1;
            cmd_o.res_code = STAT_DOUBLE;
            state_d = S_RESULT;
          end else begin
            cmd_o.rd_en       = 1'b1;
            cmd_o.rd_sel      = RD_NXT;
            cmd_o.latch_right = 1'b1;
            state_d = S_FMERGE;
          end
        end else begin
          cmd_o.advance = 1'b1;
          if (sts_i.end_reached) begin
            cmd_o.set_res  = 1'b1;
            cmd_o.res_code = STAT_NOTFOUND;
            state_d = S_RESULT;
          end else begin
            state_d = S_READ;
          end
        end
      end
      S_FMERGE: begin
        cmd_o.wr_en    = 1'b1;
        cmd_o.wr_sel   = WR_MERGE;
        cmd_o.set_res  = 1'b1;
        cmd_o.res_code = STAT_OK;
        state_d = S_RESULT;
      end
      S_RESULT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  a_accept_to_check : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == S_CHECK)
    else $error("accepted request did not enter check");

  a_no_write_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE || state_q == S_RESULT || state_q == S_READ) |-> !cmd_o.wr_en)
    else $error("header write outside a walk step");

  a_load_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || out_ready_i))
    else $error("result overwrote a pending transfer");

  a_result_next : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.set_res |=> state_q == S_RESULT)
    else $error("result set without moving to result state");

endmodule

`default_nettype wire
